[rtl/assert_macros.svh]
// assertion helpers used by the gcd core
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, held off during reset
`define ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("%m: same-cycle check failed");

// next-cycle implication, held off during reset
`define ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("%m: next-cycle check failed");

`endif

[rtl/egcd_pkg.sv]
package egcd_pkg;

	// field widths of the request and result
	localparam int VALUE_BITS = 31;
	localparam int DIV_BITS   = 31;
	localparam int COEF_BITS  = 32;

	// operand width inside the datapath
	localparam int OPERAND_BITS = 31;
	localparam int CNT_BITS     = $clog2(OPERAND_BITS);

	typedef struct packed {
		logic [VALUE_BITS-1:0] first_value;
		logic [VALUE_BITS-1:0] second_value;
	} egcd_in_t;

	typedef struct packed {
		logic [DIV_BITS-1:0]         divisor;
		logic signed [COEF_BITS-1:0] coeff_of_larger;
		logic signed [COEF_BITS-1:0] coeff_of_smaller;
		logic                        swapped;
		logic                        zero_operand;
	} egcd_out_t;

endpackage

[rtl/egcd_in_if.sv]
interface egcd_in_if;
	import egcd_pkg::*;

	logic     valid;
	logic     ready;
	egcd_in_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

[rtl/egcd_out_if.sv]
interface egcd_out_if;
	import egcd_pkg::*;

	logic      valid;
	logic      ready;
	egcd_out_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

[rtl/extended_euclid_gcd_core.sv]
// channel    | dir | payload                                         | handshake
// operands   | in  | first_value, second_value                       | valid/ready
// result     | out | divisor, coeff_of_larger, coeff_of_smaller,     | valid/ready
//            |     | swapped, zero_operand                           |
//
// one request at a time: ready only while idle
// each euclid step is a restoring division (ST_DIV) plus an update (ST_UPD),
// repeated until the remainder is zero, then the result is written in ST_FIN
// a zero smaller operand skips the loop and goes straight to ST_FIN
// arst_n clears the sequencer and the result valid; no clearing pass
// a stalled result holds in the output register; the next request is taken meanwhile
`include "assert_macros.svh"

module extended_euclid_gcd_core (
	input  logic            clk,
	input  logic            arst_n,
	egcd_in_if.sink         operands,
	egcd_out_if.source      result
);
	import egcd_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_UPD,
		ST_FIN
	} state_t;

	state_t                  state_q;
	logic [OPERAND_BITS-1:0] dvd_q;     // dividend, shifted out msb first
	logic [OPERAND_BITS-1:0] small_q;   // divisor of the current step
	logic [OPERAND_BITS-1:0] rem_q;     // partial remainder
	logic [CNT_BITS-1:0]     cnt_q;
	logic [COEF_BITS-1:0]    xc_q, xp_q, yc_q, yp_q;
	logic [COEF_BITS-1:0]    accx_q, accy_q;  // quotient times current coefficients
	logic                    swp_q;
	logic                    zero_q;
	logic                    out_valid_q;
	egcd_out_t               out_q;

	// operand ordering at the request
	logic [OPERAND_BITS-1:0] opa, opb, op_big, op_small;
	logic                    op_swap;

	// one restoring division step
	logic [OPERAND_BITS:0]   shifted;
	logic [OPERAND_BITS:0]   diff;
	logic                    qbit;
	logic                    div_last;

	assign opa      = OPERAND_BITS'(operands.payload.first_value);
	assign opb      = OPERAND_BITS'(operands.payload.second_value);
	assign op_swap  = opa < opb;
	assign op_big   = op_swap ? opb : opa;
	assign op_small = op_swap ? opa : opb;

	assign shifted  = {rem_q, dvd_q[OPERAND_BITS-1]};
	assign diff     = shifted - {1'b0, small_q};
	assign qbit     = shifted >= {1'b0, small_q};
	assign div_last = cnt_q == CNT_BITS'(OPERAND_BITS - 1);

	assign operands.ready = state_q == ST_IDLE;
	assign result.valid   = out_valid_q;
	assign result.payload = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			dvd_q       <= '0;
			small_q     <= '0;
			rem_q       <= '0;
			cnt_q       <= '0;
			xc_q        <= '0;
			xp_q        <= '0;
			yc_q        <= '0;
			yp_q        <= '0;
			accx_q      <= '0;
			accy_q      <= '0;
			swp_q       <= 1'b0;
			zero_q      <= 1'b0;
			out_q       <= '0;
		end else begin
			// result taken
			if (out_valid_q && result.ready) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (operands.valid) begin
						swp_q  <= op_swap;
						dvd_q  <= op_big;
						rem_q  <= '0;
						cnt_q  <= '0;
						accx_q <= '0;
						accy_q <= '0;
						xp_q   <= COEF_BITS'(1);
						yp_q   <= '0;
						if (op_small == '0) begin
							// no loop: gcd is the larger operand, coefficients 1 and 0
							zero_q  <= 1'b1;
							small_q <= op_big;
							xc_q    <= COEF_BITS'(1);
							yc_q    <= '0;
							state_q <= ST_FIN;
						end else begin
							zero_q  <= 1'b0;
							small_q <= op_small;
							xc_q    <= '0;
							yc_q    <= COEF_BITS'(1);
							state_q <= ST_DIV;
						end
					end
				end

				ST_DIV: begin
					rem_q  <= qbit ? diff[OPERAND_BITS-1:0] : shifted[OPERAND_BITS-1:0];
					dvd_q  <= {dvd_q[OPERAND_BITS-2:0], 1'b0};
					// horner form of quotient times coefficient, msb first
					accx_q <= {accx_q[COEF_BITS-2:0], 1'b0} + (qbit ? xc_q : '0);
					accy_q <= {accy_q[COEF_BITS-2:0], 1'b0} + (qbit ? yc_q : '0);
					cnt_q  <= cnt_q + CNT_BITS'(1);
					if (div_last) begin
						state_q <= ST_UPD;
					end
				end

				ST_UPD: begin
					if (rem_q == '0) begin
						state_q <= ST_FIN;
					end else begin
						xc_q    <= xp_q - accx_q;
						xp_q    <= xc_q;
						yc_q    <= yp_q - accy_q;
						yp_q    <= yc_q;
						dvd_q   <= small_q;
						small_q <= rem_q;
						rem_q   <= '0;
						cnt_q   <= '0;
						accx_q  <= '0;
						accy_q  <= '0;
						state_q <= ST_DIV;
					end
				end

				ST_FIN: begin
					// wait for the output register to free up
					if (!out_valid_q || result.ready) begin
						out_q.divisor          <= DIV_BITS'(small_q);
						out_q.coeff_of_larger  <= xc_q;
						out_q.coeff_of_smaller <= yc_q;
						out_q.swapped          <= swp_q;
						out_q.zero_operand     <= zero_q;
						out_valid_q            <= 1'b1;
						state_q                <= ST_IDLE;
					end
				end

				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	`ASSERT_NOW(a_div_nonzero, state_q == ST_DIV, small_q != '0)
	`ASSERT_NOW(a_rem_below_div, state_q == ST_DIV || state_q == ST_UPD, rem_q < small_q)
	`ASSERT_NOW(a_zero_coeffs, result.valid && result.payload.zero_operand,
		result.payload.coeff_of_larger == COEF_BITS'(1) && result.payload.coeff_of_smaller == '0)
	`ASSERT_NEXT(a_busy_after_req, operands.valid && operands.ready, state_q != ST_IDLE)

endmodule
